### rtl/core/dtf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dtf_pkg
// shared types and constants of the deduplicating task queue
// ----------------------------------------------------------------------------
package dtf_pkg;

    localparam int DEPTH_DEFAULT = 16;

    localparam int TYPE_W     = 3;
    localparam int ID_IN_W    = 32;
    localparam int ID_W       = 31;
    localparam int HANDLE_W   = 32;
    localparam int STATUS_W   = 3;

    localparam int IN_TDATA_W  = 72;
    localparam int OUT_TDATA_W = 72;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_INVALID   = 3'd1,
        ST_DUPLICATE = 3'd2,
        ST_FULL      = 3'd3,
        ST_EMPTY     = 3'd4
    } status_t;

    typedef enum logic [0:0] {
        OP_ENQUEUE = 1'b0,
        OP_DEQUEUE = 1'b1
    } op_t;

    // one queued task, type in the lowest bits
    typedef struct packed {
        logic [HANDLE_W-1:0] handle;
        logic [ID_W-1:0]     id;
        logic [TYPE_W-1:0]   task_type;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

endpackage : dtf_pkg
`default_nettype wire

### rtl/core/dtf_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dtf_ram
// generic single-clock ram, one write port, one read port, registered read
// ----------------------------------------------------------------------------
module dtf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire                      clk,
    input  wire                      we,
    input  wire  [$clog2(DEPTH)-1:0] waddr,
    input  wire  [WIDTH-1:0]         wdata,
    input  wire  [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule : dtf_ram
`default_nettype wire

### rtl/core/dedup_task_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dedup_task_fifo
// bounded fifo of tasks that rejects invalid, duplicate and overflow requests
// ----------------------------------------------------------------------------
// One request is worked at a time and every request returns exactly one
// result. Queued tasks (type, id, handle) live in one ram of DEPTH words with
// a registered read. A dequeue reads the head entry in S_DEQ, takes the data
// in S_DEQ_DATA and loads the output register from S_OUT once it is free. An
// enqueue with a negative id or no description is rejected as invalid; any
// other enqueue reads the queued entries from the head, one read a cycle
// with the compare in the cycle after, and stops at the first duplicate.
// The next request is taken while an earlier result still waits in the
// output register. The ram needs no clearing pass: only entries between
// head and tail are ever used.
// ----------------------------------------------------------------------------
module dedup_task_fifo #(
    parameter int DEPTH = dtf_pkg::DEPTH_DEFAULT
) (
    input  wire                                clk,
    input  wire                                rst_n,

    // request side
    input  wire                                s_tvalid,
    output logic                               s_tready,
    // task_type[2:0], task_id[34:3], description_handle[66:35],
    // description_present[67], zero[71:68]
    input  wire  [dtf_pkg::IN_TDATA_W-1:0]     s_tdata,
    // operation[0]
    input  wire                                s_tuser,

    // result side
    output logic                               m_tvalid,
    input  wire                                m_tready,
    // out_type[2:0], out_id[33:3], out_handle[65:34], zero[71:66]
    output logic [dtf_pkg::OUT_TDATA_W-1:0]    m_tdata,
    // status[2:0]
    output logic [dtf_pkg::STATUS_W-1:0]       m_tuser
);

    import dtf_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int PAD_W = OUT_TDATA_W - ENTRY_W;

    localparam logic [PTR_W-1:0] LAST_POS  = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(DEPTH);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DEQ,
        S_DEQ_DATA,
        S_SCAN,
        S_OUT
    } state_t;

    // request fields
    logic [TYPE_W-1:0]   in_type;
    logic [ID_IN_W-1:0]  in_id;
    logic [HANDLE_W-1:0] in_handle;
    logic                in_present;

    assign in_type    = s_tdata[TYPE_W-1:0];
    assign in_id      = s_tdata[TYPE_W+ID_IN_W-1:TYPE_W];
    assign in_handle  = s_tdata[TYPE_W+ID_IN_W+HANDLE_W-1:TYPE_W+ID_IN_W];
    assign in_present = s_tdata[TYPE_W+ID_IN_W+HANDLE_W];

    state_t              state_reg,     state_next;
    logic [PTR_W-1:0]    head_reg,      head_next;
    logic [CNT_W-1:0]    count_reg,     count_next;
    logic [CNT_W-1:0]    scan_idx_reg,  scan_idx_next;
    logic [PTR_W-1:0]    scan_pos_reg,  scan_pos_next;
    logic                pend_reg,      pend_next;
    entry_t              req_reg,       req_next;
    entry_t              res_reg,       res_next;
    status_t             status_reg,    status_next;
    logic                m_tvalid_reg,  m_tvalid_next;
    logic [OUT_TDATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic [STATUS_W-1:0] m_tuser_reg,   m_tuser_next;

    // ram port
    logic                ram_we;
    logic [PTR_W-1:0]    ram_waddr;
    logic [PTR_W-1:0]    ram_raddr;
    entry_t              ram_rdata;
    logic [ENTRY_W-1:0]  ram_rdata_raw;

    logic                hit;

    dtf_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (req_reg),
        .raddr (ram_raddr),
        .rdata (ram_rdata_raw)
    );

    assign ram_rdata = entry_t'(ram_rdata_raw);

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // compare of the entry read in the previous scan cycle
    assign hit = pend_reg
              && (ram_rdata.task_type == req_reg.task_type)
              && (ram_rdata.id == req_reg.id);

    always_comb
    begin
        state_next    = state_reg;
        head_next     = head_reg;
        count_next    = count_reg;
        scan_idx_next = scan_idx_reg;
        scan_pos_next = scan_pos_reg;
        pend_next     = 1'b0;
        req_next      = req_reg;
        res_next      = res_reg;
        status_next   = status_reg;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        ram_we        = 1'b0;
        ram_waddr     = scan_pos_reg;
        ram_raddr     = scan_pos_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    req_next.task_type = in_type;
                    req_next.id        = in_id[ID_W-1:0];
                    req_next.handle    = in_handle;
                    res_next           = '0;
                    status_next        = ST_OK;
                    if (op_t'(s_tuser) == OP_DEQUEUE)
                    begin
                        if (count_reg == '0)
                        begin
                            status_next = ST_EMPTY;
                            state_next  = S_OUT;
                        end
                        else
                        begin
                            state_next = S_DEQ;
                        end
                    end
                    else if (in_id[ID_IN_W-1] || !in_present)
                    begin
                        status_next = ST_INVALID;
                        state_next  = S_OUT;
                    end
                    else
                    begin
                        scan_idx_next = '0;
                        scan_pos_next = head_reg;
                        state_next    = S_SCAN;
                    end
                end
            end

            S_DEQ:
            begin
                ram_raddr  = head_reg;
                head_next  = (head_reg == LAST_POS) ? '0 : head_reg + 1'b1;
                count_next = count_reg - 1'b1;
                state_next = S_DEQ_DATA;
            end

            S_DEQ_DATA:
            begin
                res_next   = ram_rdata;
                state_next = S_OUT;
            end

            S_SCAN:
            begin
                if (hit)
                begin
                    status_next = ST_DUPLICATE;
                    state_next  = S_OUT;
                end
                else if (scan_idx_reg < count_reg)
                begin
                    // issue the next read, compare it next cycle
                    pend_next     = 1'b1;
                    scan_idx_next = scan_idx_reg + 1'b1;
                    scan_pos_next = (scan_pos_reg == LAST_POS) ? '0 : scan_pos_reg + 1'b1;
                end
                else if (count_reg == FULL_CNT)
                begin
                    status_next = ST_FULL;
                    state_next  = S_OUT;
                end
                else
                begin
                    // scan position now sits on the tail
                    ram_we     = 1'b1;
                    count_next = count_reg + 1'b1;
                    state_next = S_OUT;
                end
            end

            S_OUT:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {{PAD_W{1'b0}}, res_reg};
                    m_tuser_next  = status_reg;
                    state_next    = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            head_reg     <= '0;
            count_reg    <= '0;
            scan_idx_reg <= '0;
            scan_pos_reg <= '0;
            pend_reg     <= 1'b0;
            req_reg      <= '0;
            res_reg      <= '0;
            status_reg   <= ST_OK;
            m_tvalid_reg <= 1'b0;
            m_tdata_reg  <= '0;
            m_tuser_reg  <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            head_reg     <= head_next;
            count_reg    <= count_next;
            scan_idx_reg <= scan_idx_next;
            scan_pos_reg <= scan_pos_next;
            pend_reg     <= pend_next;
            req_reg      <= req_next;
            res_reg      <= res_next;
            status_reg   <= status_next;
            m_tvalid_reg <= m_tvalid_next;
            m_tdata_reg  <= m_tdata_next;
            m_tuser_reg  <= m_tuser_next;
        end
    end

endmodule : dedup_task_fifo
`default_nettype wire

### tb/sv/dedup_task_fifo_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dedup_task_fifo_test
// self-checking bench for the deduplicating task queue
// ----------------------------------------------------------------------------
// Requests go in on the slave stream and each one is predicted at the edge
// that accepts it, from a queue of task entries kept inside the bench. Every
// result taken from the master stream is checked field by field against the
// oldest predicted result. Directed cases cover the field extremes, invalid
// ids and absent descriptions, duplicates, a full ring with all of its
// rejection orders, and wrap of the ring. Random traffic then runs in bursts
// that fill and drain the queue, under four sender and receiver idle mixes.
// ----------------------------------------------------------------------------
module dedup_task_fifo_test;
    import dtf_pkg::*;

    localparam int QDEPTH = dtf_pkg::DEPTH_DEFAULT;

    // one predicted result: status plus the dequeued task (zero otherwise)
    typedef struct {
        status_t status;
        entry_t  entry;
    } task_result_t;

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    // task_type[2:0], task_id[34:3], description_handle[66:35],
    // description_present[67], zero[71:68]
    logic [IN_TDATA_W-1:0]  s_tdata;
    // operation[0]
    logic                   s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    // out_type[2:0], out_id[33:3], out_handle[65:34], zero[71:66]
    logic [OUT_TDATA_W-1:0] m_tdata;
    // status[2:0]
    logic [STATUS_W-1:0]    m_tuser;

    // tasks the queue should hold, oldest first
    entry_t       queued_tasks[$];
    // results predicted but not yet seen on the master side
    task_result_t pending_results[$];
    task_result_t expected_result;

    int unsigned error_count        = 0;
    int unsigned sender_idle_pct    = 0;
    int unsigned receiver_stall_pct = 0;
    int unsigned drain_cycles;

    dedup_task_fifo #(
        .DEPTH (QDEPTH)
    ) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // hard stop far beyond the slowest legal run
    initial
    begin
        #10_000_000;
        $display("end of test: mismatches");
        $finish;
    end

    // queue behavior for one accepted request; pushes the result it must give
    function automatic void predict_result(op_t op, logic [2:0] ty, logic [31:0] id,
                                           logic [31:0] handle, logic present);
        task_result_t r;
        logic         dup;
        r.status = ST_OK;
        r.entry  = '0;
        dup      = 1'b0;
        if (op == OP_ENQUEUE)
        begin
            // invalid wins over duplicate, duplicate wins over full
            if (id[31] || !present)
                r.status = ST_INVALID;
            else
            begin
                foreach (queued_tasks[i])
                    if (queued_tasks[i].id == id[30:0] && queued_tasks[i].task_type == ty)
                        dup = 1'b1;
                if (dup)
                    r.status = ST_DUPLICATE;
                else if (queued_tasks.size() >= QDEPTH)
                    r.status = ST_FULL;
                else
                    queued_tasks.push_back('{handle: handle, id: id[30:0], task_type: ty});
            end
        end
        else if (queued_tasks.size() == 0)
            r.status = ST_EMPTY;
        else
            r.entry = queued_tasks.pop_front();
        pending_results.push_back(r);
    endfunction

    // drive one request, hold it until accepted, then predict it
    task automatic send_request(op_t op, logic [2:0] ty, logic [31:0] id,
                                logic [31:0] handle, logic present);
        if (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct)
        begin
            s_tvalid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < sender_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {4'b0, present, handle, id, ty};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predict_result(op, ty, id, handle, present);
    endtask

    // sender drops valid and holds off until every outstanding request has
    // its result
    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // result checker and receiver backpressure
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (pending_results.size() == 0)
                begin
                    error_count++;
                    $display("%0t: unexpected result, expected none, actual status %0d data %h",
                             $time, m_tuser, m_tdata);
                end
                else
                begin
                    expected_result = pending_results.pop_front();
                    if (m_tuser !== expected_result.status)
                    begin
                        error_count++;
                        $display("%0t: status expected %0d actual %0d",
                                 $time, expected_result.status, m_tuser);
                    end
                    if (m_tdata[2:0] !== expected_result.entry.task_type)
                    begin
                        error_count++;
                        $display("%0t: out_type expected %0d actual %0d",
                                 $time, expected_result.entry.task_type, m_tdata[2:0]);
                    end
                    if (m_tdata[33:3] !== expected_result.entry.id)
                    begin
                        error_count++;
                        $display("%0t: out_id expected %h actual %h",
                                 $time, expected_result.entry.id, m_tdata[33:3]);
                    end
                    if (m_tdata[65:34] !== expected_result.entry.handle)
                    begin
                        error_count++;
                        $display("%0t: out_handle expected %h actual %h",
                                 $time, expected_result.entry.handle, m_tdata[65:34]);
                    end
                end
            end
            m_tready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    // field extremes, invalid and duplicate rejection, empty dequeue
    task automatic test_directed_cases();
        send_request(OP_DEQUEUE, 3'd5, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);  // empty
        send_request(OP_ENQUEUE, 3'd1, 32'hFFFF_FFFF, 32'h1234_5678, 1'b1);  // id -1
        send_request(OP_ENQUEUE, 3'd2, 32'h8000_0000, 32'h0000_0001, 1'b1);  // most negative
        send_request(OP_ENQUEUE, 3'd3, 32'd5, 32'hAAAA_5555, 1'b0);          // no description
        send_request(OP_ENQUEUE, 3'd4, 32'hC000_0000, 32'h0, 1'b0);          // both faults
        send_request(OP_ENQUEUE, 3'd0, 32'd0, 32'h0, 1'b1);                  // zero handle is fine
        send_request(OP_ENQUEUE, 3'd7, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1);  // type seven, max id
        send_request(OP_ENQUEUE, 3'd6, 32'd0, 32'h0000_0123, 1'b1);          // same id, other type
        send_request(OP_ENQUEUE, 3'd0, 32'd0, 32'h5555_AAAA, 1'b1);          // duplicate
        send_request(OP_ENQUEUE, 3'd7, 32'h7FFF_FFFF, 32'h0, 1'b0);          // invalid before dup
        send_request(OP_ENQUEUE, 3'd7, 32'h7FFF_FFFE, 32'h8000_0000, 1'b1);
        // pause so the dequeues run against a settled queue
        wait_for_results();
        send_request(OP_DEQUEUE, 3'd0, 32'd0, 32'd0, 1'b0);
        send_request(OP_DEQUEUE, 3'd7, 32'h8000_0000, 32'hFFFF_FFFF, 1'b1);
        send_request(OP_DEQUEUE, 3'd0, 32'd0, 32'd0, 1'b0);
        // a removed task no longer counts as a duplicate
        send_request(OP_ENQUEUE, 3'd0, 32'd0, 32'hDEAD_0001, 1'b1);
        send_request(OP_DEQUEUE, 3'd0, 32'd0, 32'd0, 1'b0);
        send_request(OP_DEQUEUE, 3'd0, 32'd0, 32'd0, 1'b0);
        send_request(OP_DEQUEUE, 3'd0, 32'd0, 32'd0, 1'b0);                  // empty again
    endtask

    // fill the ring, check full against duplicate and invalid order, drain it
    task automatic test_full_queue();
        for (int i = 0; i < QDEPTH; i++)
            send_request(OP_ENQUEUE, 3'(i), 32'(1000 + i), $urandom, 1'b1);
        send_request(OP_ENQUEUE, 3'd1, 32'd2000, 32'h0F0F_0F0F, 1'b1);       // full
        send_request(OP_ENQUEUE, 3'd3, 32'd1003, 32'h0, 1'b1);               // dup wins over full
        send_request(OP_ENQUEUE, 3'd3, 32'hFFFF_FC15, 32'h0, 1'b1);          // invalid wins
        send_request(OP_ENQUEUE, 3'd2, 32'd2001, 32'h0, 1'b0);
        wait_for_results();
        for (int i = 0; i <= QDEPTH; i++)
            send_request(OP_DEQUEUE, 3'($urandom), $urandom, $urandom, 1'($urandom));
    endtask

    // bursts that lean toward filling, draining or mixing; small key pool
    // so duplicates and a full ring come up often
    task automatic test_random_traffic(int unsigned idle_pct, int unsigned stall_pct,
                                       int unsigned count);
        int unsigned sent;
        int unsigned burst_len;
        int unsigned enqueue_pct;
        int unsigned pick;
        logic [31:0] id;
        op_t         op;
        sent               = 0;
        sender_idle_pct    = idle_pct;
        receiver_stall_pct = stall_pct;
        while (sent < count)
        begin
            burst_len = $urandom_range(40, 5);
            case ($urandom_range(2))
                0:       enqueue_pct = 85;
                1:       enqueue_pct = 20;
                default: enqueue_pct = 55;
            endcase
            for (int n = 0; n < burst_len && sent < count; n++)
            begin
                pick = $urandom_range(99);
                if (pick < 60)
                    id = 32'($urandom_range(11));
                else if (pick < 80)
                    id = {1'b0, 31'($urandom)};
                else if (pick < 90)
                    id = {1'b1, 31'($urandom)};
                else
                    id = $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
                op = ($urandom_range(99) < enqueue_pct) ? OP_ENQUEUE : OP_DEQUEUE;
                send_request(op, 3'($urandom_range(7)), id, $urandom,
                             ($urandom_range(99) < 92));
                sent++;
            end
            // now and then let the block run dry before the next burst
            if ($urandom_range(7) == 0)
                wait_for_results();
        end
    endtask

    initial
    begin
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= 1'b0;
        m_tready <= 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_cases();
        test_full_queue();
        test_random_traffic(0, 0, 312);
        test_random_traffic(78, 0, 312);
        test_random_traffic(0, 78, 312);
        test_random_traffic(33, 33, 312);
        s_tvalid <= 1'b0;

        // let the last results come out, bounded
        drain_cycles = 0;
        while (pending_results.size() != 0 && drain_cycles < 20000)
        begin
            @(posedge clk);
            drain_cycles++;
        end
        if (pending_results.size() != 0)
        begin
            error_count++;
            $display("%0t: %0d results still outstanding, expected none",
                     $time, pending_results.size());
        end
        // catch any stray extra result
        repeat (30) @(posedge clk);

        if (error_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
